FILE: design/per_source_flow_stats_table_core_defines.svh
// Assertion macros shared by the flow statistics table modules.
`ifndef PER_SOURCE_FLOW_STATS_TABLE_CORE_DEFINES_SVH
`define PER_SOURCE_FLOW_STATS_TABLE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: pre holds, so post holds in that cycle.
`define PFST_ASSERT_SAME(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("pfst same-cycle check failed");
// Next-cycle implication: pre holds, so post holds in the next cycle.
`define PFST_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("pfst next-cycle check failed");
`else
`define PFST_ASSERT_SAME(label, clk, rst, pre, post)
`define PFST_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/pfst_pkg.sv
// Types and constants of the per-source flow statistics table.
`timescale 1ns / 1ps
package pfst_pkg;

  localparam logic       MODE_RECORD = 1'b0;
  localparam logic       MODE_QUERY  = 1'b1;
  localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [31:0] address;
    logic [15:0] byte_count;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    logic        found;
    logic        created;
    logic        bucket_full;
    logic [31:0] packet_total;
    logic [31:0] byte_total;
    logic [31:0] start_time;
  } result_t;

  typedef struct packed {
    logic [31:0] address;
    logic [31:0] bytes;
    logic [31:0] packets;
    logic [31:0] start;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic capture_count;
    logic advance_way;
    logic set_hit;
    logic finish;
    logic clear_step;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic way_lt_count;
    logic addr_match;
    logic clear_last;
  } status_t;

endpackage

FILE: design/pfst_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pfst_ctrl.sv
// Sequencer of the flow statistics table: clear pass, lookup scan, update.
`timescale 1ns / 1ps
`include "per_source_flow_stats_table_core_defines.svh"
module pfst_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pfst_pkg::status_t status,
  output pfst_pkg::cmd_t    cmd,
  output logic              busy
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_COUNT  = 6'b000100,
    ST_PROBE  = 6'b001000,
    ST_MATCH  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        cmd.capture_count = 1'b1;
        state_next        = ST_PROBE;
      end
      ST_PROBE: begin
        if (status.way_lt_count) begin
          state_next = ST_MATCH;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_MATCH: begin
        if (status.addr_match) begin
          cmd.set_hit = 1'b1;
          state_next  = ST_FINISH;
        end else begin
          cmd.advance_way = 1'b1;
          state_next      = ST_PROBE;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `PFST_ASSERT_NEXT(a_accept_reads_count, clk, rst, start && !busy, state == ST_COUNT)
  `PFST_ASSERT_NEXT(a_miss_continues_scan, clk, rst, cmd.advance_way, state == ST_PROBE)
  `PFST_ASSERT_NEXT(a_finish_returns_idle, clk, rst, cmd.finish, state == ST_IDLE && !busy)

endmodule

FILE: design/pfst_datapath.sv
// Datapath of the flow statistics table: bucket fill counts, entry store, update.
`timescale 1ns / 1ps
`include "per_source_flow_stats_table_core_defines.svh"
module pfst_datapath #(
  parameter int INDEX_BITS = 10,
  parameter int WAYS       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  pfst_pkg::request_t request,
  input  pfst_pkg::cmd_t     cmd,
  output pfst_pkg::status_t  status,
  output logic               done,
  output pfst_pkg::result_t  result
);

  localparam int BUCKETS  = 2 ** INDEX_BITS;
  localparam int DEPTH    = BUCKETS * WAYS;
  localparam int ENTRY_AW = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(WAYS + 1);
  localparam int ENTRY_W  = $bits(pfst_pkg::entry_t);

  pfst_pkg::request_t req;
  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] way;
  logic                hit;
  logic [INDEX_BITS-1:0] clr_idx;

  logic [INDEX_BITS-1:0] bucket;
  logic [ENTRY_AW-1:0]   entry_addr;

  logic                  cnt_we;
  logic [INDEX_BITS-1:0] cnt_waddr;
  logic [CNT_BITS-1:0]   cnt_wdata;
  logic [INDEX_BITS-1:0] cnt_raddr;
  logic [CNT_BITS-1:0]   cnt_rdata;

  logic                  ent_we;
  pfst_pkg::entry_t      ent_wdata;
  pfst_pkg::entry_t      ent_rdata;

  logic                  is_record;
  logic                  can_create;
  logic [32:0]           byte_sum;
  logic [31:0]           new_bytes;
  logic [31:0]           new_packets;
  pfst_pkg::result_t     result_next;

  assign bucket     = req.address[INDEX_BITS-1:0];
  assign entry_addr = ENTRY_AW'(bucket) * ENTRY_AW'(WAYS) + ENTRY_AW'(way);
  assign cnt_raddr  = cmd.load ? request.address[INDEX_BITS-1:0] : bucket;

  assign is_record  = (req.mode == pfst_pkg::MODE_RECORD);
  assign can_create = (count < CNT_BITS'(WAYS));

  assign byte_sum    = {1'b0, ent_rdata.bytes} + {17'b0, req.byte_count};
  assign new_bytes   = byte_sum[32] ? pfst_pkg::SAT32 : byte_sum[31:0];
  assign new_packets = (ent_rdata.packets == pfst_pkg::SAT32) ? pfst_pkg::SAT32
                                                              : ent_rdata.packets + 32'd1;

  always_comb begin
    result_next = '0;
    ent_we      = 1'b0;
    ent_wdata   = ent_rdata;
    cnt_we      = cmd.clear_step;
    cnt_waddr   = clr_idx;
    cnt_wdata   = '0;
    if (cmd.finish) begin
      if (hit) begin
        result_next.found      = 1'b1;
        result_next.start_time = ent_rdata.start;
        if (is_record) begin
          ent_we                   = 1'b1;
          ent_wdata.bytes          = new_bytes;
          ent_wdata.packets        = new_packets;
          result_next.packet_total = new_packets;
          result_next.byte_total   = new_bytes;
        end else begin
          result_next.packet_total = ent_rdata.packets;
          result_next.byte_total   = ent_rdata.bytes;
        end
      end else if (is_record && can_create) begin
        ent_we                   = 1'b1;
        ent_wdata.address        = req.address;
        ent_wdata.bytes          = {16'b0, req.byte_count};
        ent_wdata.packets        = 32'd1;
        ent_wdata.start          = req.now;
        cnt_we                   = 1'b1;
        cnt_waddr                = bucket;
        cnt_wdata                = count + CNT_BITS'(1);
        result_next.created      = 1'b1;
        result_next.packet_total = 32'd1;
        result_next.byte_total   = {16'b0, req.byte_count};
        result_next.start_time   = req.now;
      end else if (is_record) begin
        result_next.bucket_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.clear_step) begin
        clr_idx <= clr_idx + INDEX_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
      way <= '0;
      hit <= 1'b0;
    end
    if (cmd.capture_count) begin
      count <= cnt_rdata;
    end
    if (cmd.advance_way) begin
      way <= way + CNT_BITS'(1);
    end
    if (cmd.set_hit) begin
      hit <= 1'b1;
    end
    if (cmd.finish) begin
      result <= result_next;
    end
  end

  assign status.way_lt_count = (way < count);
  assign status.addr_match   = (ent_rdata.address == req.address);
  assign status.clear_last   = &clr_idx;

  pfst_ram #(
    .WIDTH (CNT_BITS),
    .DEPTH (BUCKETS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (entry_addr),
    .wdata (ent_wdata),
    .raddr (entry_addr),
    .rdata (ent_rdata)
  );

  `PFST_ASSERT_SAME(a_found_not_created, clk, rst, done, !(result.found && result.created))
  `PFST_ASSERT_SAME(a_full_is_empty, clk, rst, done && result.bucket_full,
                    result.packet_total == 32'd0 && !result.found)
  `PFST_ASSERT_SAME(a_create_one_packet, clk, rst, done && result.created,
                    result.packet_total == 32'd1)

endmodule

FILE: design/per_source_flow_stats_table_core.sv
// Top level of the per-source flow statistics table.
//
//   channel   direction  handshake            payload
//   request   in         start, busy          request (pfst_pkg::request_t)
//   result    out        done (one cycle)     result  (pfst_pkg::result_t)
//
// A request reads its bucket's fill count k (0 <= k <= WAYS), then probes the
// filled ways one at a time, each a registered read of the entry memory, until
// a way matches or all k are probed; the result register then takes the
// result. busy drops in the cycle the result shows.
// After reset the bucket fill-count memory is swept to zero, one bucket a
// cycle, through all 2**INDEX_BITS buckets; busy stays high throughout.
// The result receiver cannot stall: done is high for exactly one cycle, and the
// result stays on the ports until the next request's result replaces it.
`timescale 1ns / 1ps
module per_source_flow_stats_table_core #(
  parameter int INDEX_BITS = 10,
  parameter int WAYS       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pfst_pkg::request_t request,
  output logic               done,
  output pfst_pkg::result_t  result
);

  pfst_pkg::cmd_t    cmd;
  pfst_pkg::status_t status;

  // Sequence each request: read the bucket fill count, scan the filled ways,
  // then, for a record, write back the updated or new entry, and strobe the result.
  pfst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Hold the request, the fill-count and entry memories, and the result register.
  pfst_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .WAYS       (WAYS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .done    (done),
    .result  (result)
  );

endmodule
